// ===== hdl/tsa_pkg.sv =====
// ----------------------------------------------------------------------------
// tsa_pkg: shared types and constants of the text slot allocator
// Field widths of the message beat, the slot write record and the default
// slot count.
// ----------------------------------------------------------------------------
`default_nettype none

package tsa_pkg;

  localparam int unsigned SlotsDefault = 6;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned IdW    = 32;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned DurW   = 16;
  localparam int unsigned SlotOW = 3;

  // s_axis tdata: channel, request_id, now, fade_in, hold, fade_out
  localparam int unsigned InDataW  = 120;
  localparam int unsigned OutDataW = 8;

  typedef enum logic {
    FUNC_PLAIN = 1'b0,
    FUNC_AUTO  = 1'b1
  } func_e;

  typedef struct packed {
    func_e             func;
    logic [ChanW-1:0]  channel;
    logic [IdW-1:0]    request_id;
    logic [TimeW-1:0]  now;
    logic [DurW-1:0]   fade_in;
    logic [DurW-1:0]   hold;
    logic [DurW-1:0]   fade_out;
  } item_t;

  // contents written to the chosen slot
  typedef struct packed {
    logic              en;
    logic [TimeW-1:0]  expiry;
    logic [IdW-1:0]    owner;
  } slot_wr_t;

endpackage

`default_nettype wire

// ===== hdl/tsa_slot_file.sv =====
// ----------------------------------------------------------------------------
// tsa_slot_file: expiry and owner registers of all slots
// One write port; every slot is visible in parallel to the picker.
// ----------------------------------------------------------------------------
`default_nettype none

module tsa_slot_file #(
  parameter int unsigned SLOTS = tsa_pkg::SlotsDefault,
  localparam int unsigned SlotW = $clog2(SLOTS)
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire tsa_pkg::slot_wr_t        wr_i,
  input  wire logic [SlotW-1:0]         wr_idx_i,
  output logic [tsa_pkg::TimeW-1:0]     expiry_o [SLOTS],
  output logic [tsa_pkg::IdW-1:0]       owner_o  [SLOTS]
);

  logic [tsa_pkg::TimeW-1:0] expiry_q [SLOTS];
  logic [tsa_pkg::IdW-1:0]   owner_q  [SLOTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        expiry_q[i] <= '0;
        owner_q[i]  <= '0;
      end
    end else if (wr_i.en) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (wr_idx_i == SlotW'(i)) begin
          expiry_q[i] <= wr_i.expiry;
          owner_q[i]  <= wr_i.owner;
        end
      end
    end
  end

  assign expiry_o = expiry_q;
  assign owner_o  = owner_q;

endmodule

`default_nettype wire

// ===== hdl/tsa_pick.sv =====
// ----------------------------------------------------------------------------
// tsa_pick: slot selection for one message
// Channel modulo slot count, owner match search, earliest-expiry tree and the
// saturating expiry sum.
// ----------------------------------------------------------------------------
`default_nettype none

module tsa_pick #(
  parameter int unsigned SLOTS = tsa_pkg::SlotsDefault,
  localparam int unsigned SlotW = $clog2(SLOTS)
) (
  input  wire tsa_pkg::item_t           item_i,
  input  wire logic [tsa_pkg::TimeW-1:0] expiry_i [SLOTS],
  input  wire logic [tsa_pkg::IdW-1:0]   owner_i  [SLOTS],
  output logic [SlotW-1:0]              slot_o,
  output tsa_pkg::slot_wr_t             wr_o
);

  localparam int unsigned RcpShift = 16;
  localparam int unsigned RcpW     = RcpShift + 1;
  localparam int unsigned Rcp      = ((1 << RcpShift) + SLOTS - 1) / SLOTS;
  localparam int unsigned ProdW    = tsa_pkg::ChanW + RcpW;
  localparam int unsigned Leaves   = 1 << SlotW;
  localparam int unsigned SumW     = tsa_pkg::TimeW + 2;

  logic [ProdW-1:0]           prod;
  logic [tsa_pkg::ChanW-1:0]  quo;
  logic [tsa_pkg::ChanW-1:0]  rem;
  logic [SlotW-1:0]           start;
  logic [SlotW-1:0]           hit;
  logic                       found;
  logic                       keep;
  logic [SumW-1:0]            sum;

  logic [tsa_pkg::TimeW-1:0]  node_exp [2*Leaves];
  logic [SlotW-1:0]           node_idx [2*Leaves];
  logic                       node_vld [2*Leaves];
  logic                       take_right;

  // quotient by reciprocal multiply, exact over the whole channel range
  always_comb begin
    prod  = ProdW'(item_i.channel) * ProdW'(Rcp);
    quo   = prod[RcpShift +: tsa_pkg::ChanW];
    rem   = item_i.channel - tsa_pkg::ChanW'(quo * tsa_pkg::ChanW'(SLOTS));
    start = rem[SlotW-1:0];
  end

  // highest slot owned by the request id
  always_comb begin
    hit   = '0;
    found = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (owner_i[i] == item_i.request_id) begin
        hit   = SlotW'(i);
        found = 1'b1;
      end
    end
  end

  // earliest expiry, ties go to the lower index (left child)
  always_comb begin
    take_right = 1'b0;
    for (int n = 0; n < 2 * Leaves; n++) begin
      node_exp[n] = '0;
      node_idx[n] = '0;
      node_vld[n] = 1'b0;
    end
    for (int i = 0; i < Leaves; i++) begin
      if (i < SLOTS) begin
        node_exp[Leaves+i] = expiry_i[i];
        node_vld[Leaves+i] = 1'b1;
      end
      node_idx[Leaves+i] = SlotW'(i);
    end
    for (int n = Leaves - 1; n >= 1; n--) begin
      take_right = node_vld[2*n+1] &&
                   (!node_vld[2*n] || (node_exp[2*n+1] < node_exp[2*n]));
      node_exp[n] = take_right ? node_exp[2*n+1] : node_exp[2*n];
      node_idx[n] = take_right ? node_idx[2*n+1] : node_idx[2*n];
      node_vld[n] = node_vld[2*n] || node_vld[2*n+1];
    end
  end

  always_comb begin
    keep = !(expiry_i[start] > item_i.now) || (owner_i[start] == item_i.request_id);
    if (item_i.func == tsa_pkg::FUNC_PLAIN || keep) begin
      slot_o = start;
    end else if (found) begin
      slot_o = hit;
    end else begin
      slot_o = node_idx[1];
    end
  end

  always_comb begin
    sum = SumW'(item_i.now) + SumW'(item_i.fade_in) + SumW'(item_i.hold)
        + SumW'(item_i.fade_out);
    wr_o.en     = 1'b1;
    wr_o.expiry = (sum[SumW-1:tsa_pkg::TimeW] != '0) ? '1 : sum[tsa_pkg::TimeW-1:0];
    wr_o.owner  = (item_i.func == tsa_pkg::FUNC_AUTO) ? item_i.request_id : '0;
  end

endmodule

`default_nettype wire

// ===== hdl/text_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// text_slot_allocator: display slot picker for text messages
// Chooses and writes the slot of each message from expiry and owner state.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one message per beat: tuser is func (0 plain, 1 auto),
//   tdata packs channel, request_id, now, fade_in, hold and fade_out.
//   m_axis returns one beat per message with the chosen slot in tdata[2:0].
//   A beat lands in an input register; the picker works on it there and, once
//   the result register is free or being drained, updates the slot's expiry
//   and owner and loads the result register. While m_axis does not stall, one
//   message per cycle is sustained: the slot state is read and written in the
//   same cycle, so the following message already sees the update. The
//   critical path is the earliest-expiry compare tree plus the slot write-back.
//   Reset clears all slot expiry and owner values to zero and empties both
//   registers. When m_axis stalls, the result register holds and the input
//   register still takes one beat, after which s_axis_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module text_slot_allocator #(
  parameter int unsigned SLOTS = tsa_pkg::SlotsDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // channel[7:0], request_id[39:8], now[71:40], fade_in[87:72],
  // hold[103:88], fade_out[119:104]
  input  wire logic [tsa_pkg::InDataW-1:0]   s_axis_tdata,
  // func[0]
  input  wire logic                          s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // slot[2:0], zero[7:3]
  output logic [tsa_pkg::OutDataW-1:0]       m_axis_tdata
);

  localparam int unsigned SlotW = $clog2(SLOTS);

  tsa_pkg::item_t             item_d, item_q;
  logic                       in_vld_q;
  logic [tsa_pkg::SlotOW-1:0] slot_q;
  logic                       out_vld_q;
  logic                       advance;

  logic [tsa_pkg::TimeW-1:0]  expiry [SLOTS];
  logic [tsa_pkg::IdW-1:0]    owner  [SLOTS];
  logic [SlotW-1:0]           pick_slot;
  tsa_pkg::slot_wr_t          pick_wr;
  tsa_pkg::slot_wr_t          wr;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  always_comb begin
    item_d.func       = tsa_pkg::func_e'(s_axis_tuser);
    item_d.channel    = s_axis_tdata[7:0];
    item_d.request_id = s_axis_tdata[39:8];
    item_d.now        = s_axis_tdata[71:40];
    item_d.fade_in    = s_axis_tdata[87:72];
    item_d.hold       = s_axis_tdata[103:88];
    item_d.fade_out   = s_axis_tdata[119:104];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q <= item_d;
    end
  end

  tsa_pick #(
    .SLOTS (SLOTS)
  ) u_pick (
    .item_i   (item_q),
    .expiry_i (expiry),
    .owner_i  (owner),
    .slot_o   (pick_slot),
    .wr_o     (pick_wr)
  );

  always_comb begin
    wr    = pick_wr;
    wr.en = pick_wr.en && advance;
  end

  tsa_slot_file #(
    .SLOTS (SLOTS)
  ) u_slot_file (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (wr),
    .wr_idx_i (pick_slot),
    .expiry_o (expiry),
    .owner_o  (owner)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  // slot number wraps to the 3-bit field for large slot counts
  always_ff @(posedge clk_i) begin
    if (advance) begin
      slot_q <= tsa_pkg::SlotOW'(pick_slot);
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = tsa_pkg::OutDataW'(slot_q);

endmodule

`default_nettype wire
